// ----- sv/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, types and helpers for the Taylor-series sine pipeline.
// ----------------------------------------------------------------------------
package tss_pkg;

	// I/O format: signed Q3.28 on both sides
	localparam int ANGLE_W   = 32;
	localparam int IO_FRAC   = 28;

	// internal fraction bits of all magnitudes and of the running sum
	localparam int FRAC_BITS = 28;

	localparam int MAX_TERMS_DEF = 16;

	// |x| <= 8.0, x^2 <= 64, largest term < 512, sum of |terms| < 2048
	localparam int AX_W  = FRAC_BITS + 4;
	localparam int X2_W  = FRAC_BITS + 7;
	localparam int T_W   = FRAC_BITS + 9;
	localparam int N_W   = FRAC_BITS + 16;
	localparam int M_W   = N_W - 2;
	localparam int SUM_W = FRAC_BITS + 13;
	localparam int MG_W  = SUM_W + ((IO_FRAC > FRAC_BITS) ? (IO_FRAC - FRAC_BITS) : 0);

	localparam int               NUM_TERMS_W   = 5;
	localparam logic [NUM_TERMS_W-1:0] NUM_TERMS_RST = 5'd8;

	// what travels with an item from term to term
	typedef struct packed {
		logic                    xneg;
		logic [X2_W-1:0]         x2;
		logic signed [SUM_W-1:0] sum;
	} tss_ctx_t;

	// add or subtract one term into the running sum when enabled
	function automatic logic signed [SUM_W-1:0] tss_accum(
		input logic signed [SUM_W-1:0] acc,
		input logic [T_W-1:0]          term,
		input logic                    sub,
		input logic                    en
	);
		logic signed [SUM_W-1:0] ext;
		ext = signed'(SUM_W'(term));
		if (!en) begin
			return acc;
		end
		return sub ? (acc - ext) : (acc + ext);
	endfunction

endpackage

// ----- sv/tss_front.sv -----
// ----------------------------------------------------------------------------
// tss_front
// Angle magnitude, conversion to internal scale and x^2, three stages.
// ----------------------------------------------------------------------------
module tss_front import tss_pkg::*; #(
	parameter int NT_W = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic signed [ANGLE_W-1:0] angle,
	input  logic [NT_W-1:0]           in_nt,
	output logic                      out_valid,
	output tss_ctx_t                  out_ctx,
	output logic [T_W-1:0]            out_t,
	output logic [NT_W-1:0]           out_nt
);

	localparam int AL   = AX_W / 2;
	localparam int AH   = AX_W - AL;
	localparam int SQ_W = 2 * AX_W;
	localparam logic [SQ_W-1:0] RND_C = SQ_W'(1) << (FRAC_BITS - 1);

	logic [ANGLE_W-1:0] mag_in;
	logic [AX_W-1:0]    ax;
	logic [SQ_W-1:0]    sq_sum;

	logic                 v_s1, v_s2, v_s3;
	logic                 xneg_s1, xneg_s2, xneg_s3;
	logic [NT_W-1:0]      nt_s1, nt_s2, nt_s3;
	logic [AX_W-1:0]      ax_s1, ax_s2, ax_s3;
	logic [AL+AX_W-1:0]   sql_s2;
	logic [AH+AX_W-1:0]   sqh_s2;
	logic [X2_W-1:0]      x2_s3;

	assign mag_in = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;

	if (FRAC_BITS >= IO_FRAC) begin : g_up
		assign ax = AX_W'(mag_in) << (FRAC_BITS - IO_FRAC);
	end else begin : g_dn
		localparam int SH = IO_FRAC - FRAC_BITS;
		logic [ANGLE_W:0] rnd;
		assign rnd = {1'b0, mag_in} + ((ANGLE_W + 1)'(1) << (SH - 1));
		assign ax  = AX_W'(rnd >> SH);
	end

	assign sq_sum = (SQ_W'(sqh_s2) << AL) + SQ_W'(sql_s2) + RND_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xneg_s1 <= angle[ANGLE_W-1];
			nt_s1   <= in_nt;
			ax_s1   <= ax;

			xneg_s2 <= xneg_s1;
			nt_s2   <= nt_s1;
			ax_s2   <= ax_s1;
			sql_s2  <= (AL + AX_W)'(ax_s1[AL-1:0]) * (AL + AX_W)'(ax_s1);
			sqh_s2  <= (AH + AX_W)'(ax_s1[AX_W-1:AL]) * (AH + AX_W)'(ax_s1);

			xneg_s3 <= xneg_s2;
			nt_s3   <= nt_s2;
			ax_s3   <= ax_s2;
			x2_s3   <= sq_sum[FRAC_BITS +: X2_W];
		end
	end

	assign out_valid   = v_s3;
	assign out_ctx.xneg = xneg_s3;
	assign out_ctx.x2   = x2_s3;
	assign out_ctx.sum  = '0;
	assign out_t       = T_W'(ax_s3);
	assign out_nt      = nt_s3;

endmodule

// ----- sv/tss_term.sv -----
// ----------------------------------------------------------------------------
// tss_term
// One series term: adds term K-1 to the sum and forms
// t(K) = round(round(t(K-1) * x2 / 2^F) / ((2K)(2K+1))), six stages.
// ----------------------------------------------------------------------------
module tss_term import tss_pkg::*; #(
	parameter int K    = 1,
	parameter int NT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  tss_ctx_t         in_ctx,
	input  logic [T_W-1:0]   in_t,
	input  logic [NT_W-1:0]  in_nt,
	output logic             out_valid,
	output tss_ctx_t         out_ctx,
	output logic [T_W-1:0]   out_t,
	output logic [NT_W-1:0]  out_nt
);

	localparam int TL   = T_W / 2;
	localparam int TH   = T_W - TL;
	localparam int P_W  = T_W + X2_W;
	localparam int NL   = N_W / 2;
	localparam int NH   = N_W - NL;
	localparam int QP_W = N_W + M_W;
	localparam int D    = (2 * K) * (2 * K + 1);
	localparam int HALF_D = D / 2;
	localparam longint unsigned M = (longint'(1) << N_W) / D;
	localparam logic [M_W-1:0] M_V = M_W'(M);
	localparam logic [N_W-1:0] D_N = N_W'(D);
	localparam logic PREV_ODD = 1'((K - 1) % 2);
	// round-half-up on the x2 product plus D/2 for the divide, folded together
	localparam logic [P_W-1:0] RND_C =
		(P_W'(HALF_D) << FRAC_BITS) | (P_W'(1) << (FRAC_BITS - 1));

	tss_ctx_t         ctx_n;
	logic [P_W-1:0]   p_sum;
	logic [QP_W-1:0]  q_sum;

	logic            v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	tss_ctx_t        ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;
	logic [NT_W-1:0] nt_s1, nt_s2, nt_s3, nt_s4, nt_s5, nt_s6;
	logic [TL+X2_W-1:0] ppl_s1;
	logic [TH+X2_W-1:0] pph_s1;
	logic [N_W-1:0]  n_s2, n_s3, n_s4;
	logic [NL+M_W-1:0] ql_s3;
	logic [NH+M_W-1:0] qh_s3;
	logic [M_W-1:0]  q0_s4, q0_s5;
	logic [N_W-1:0]  r_s5;
	logic [T_W-1:0]  t_s6;

	always_comb begin
		ctx_n     = in_ctx;
		ctx_n.sum = tss_accum(in_ctx.sum, in_t, in_ctx.xneg ^ PREV_ODD,
			NT_W'(K - 1) < in_nt);
	end

	assign p_sum = (P_W'(pph_s1) << TL) + P_W'(ppl_s1) + RND_C;
	assign q_sum = (QP_W'(qh_s3) << NL) + QP_W'(ql_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1 <= ctx_n;
			ctx_s2 <= ctx_s1;
			ctx_s3 <= ctx_s2;
			ctx_s4 <= ctx_s3;
			ctx_s5 <= ctx_s4;
			ctx_s6 <= ctx_s5;
			nt_s1  <= in_nt;
			nt_s2  <= nt_s1;
			nt_s3  <= nt_s2;
			nt_s4  <= nt_s3;
			nt_s5  <= nt_s4;
			nt_s6  <= nt_s5;

			// t * x2, split in two partial products
			ppl_s1 <= (TL + X2_W)'(in_t[TL-1:0]) * (TL + X2_W)'(in_ctx.x2);
			pph_s1 <= (TH + X2_W)'(in_t[T_W-1:TL]) * (TH + X2_W)'(in_ctx.x2);

			// dividend for the rounded divide
			n_s2 <= p_sum[FRAC_BITS +: N_W];

			// reciprocal multiply
			n_s3  <= n_s2;
			ql_s3 <= (NL + M_W)'(n_s2[NL-1:0]) * (NL + M_W)'(M_V);
			qh_s3 <= (NH + M_W)'(n_s2[N_W-1:NL]) * (NH + M_W)'(M_V);

			// quotient estimate, low by at most one
			n_s4  <= n_s3;
			q0_s4 <= q_sum[N_W +: M_W];

			r_s5  <= n_s4 - N_W'(q0_s4) * D_N;
			q0_s5 <= q0_s4;

			t_s6 <= T_W'(q0_s5 + M_W'(r_s5 >= D_N));
		end
	end

	assign out_valid = v_s6;
	assign out_ctx   = ctx_s6;
	assign out_t     = t_s6;
	assign out_nt    = nt_s6;

endmodule

// ----- sv/tss_final.sv -----
// ----------------------------------------------------------------------------
// tss_final
// Adds the last term, rescales to Q3.28 and saturates, three stages.
// ----------------------------------------------------------------------------
module tss_final import tss_pkg::*; #(
	parameter int K    = 15,
	parameter int NT_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  tss_ctx_t           in_ctx,
	input  logic [T_W-1:0]     in_t,
	input  logic [NT_W-1:0]    in_nt,
	output logic               out_valid,
	output logic [ANGLE_W-1:0] sine,
	output logic               overflow
);

	localparam logic K_ODD = 1'(K % 2);
	localparam logic [MG_W-1:0] LIM_POS = MG_W'(64'h7FFF_FFFF);
	localparam logic [MG_W-1:0] LIM_NEG = MG_W'(64'h8000_0000);

	logic [MG_W-1:0]    mag_sc;
	logic [MG_W-1:0]    lim;
	logic               ovf;
	logic [ANGLE_W-1:0] m32;

	logic                    v_s1, v_s2, v_s3;
	logic signed [SUM_W-1:0] sum_s1;
	logic                    neg_s2;
	logic [SUM_W-1:0]        mag_s2;
	logic [ANGLE_W-1:0]      sine_s3;
	logic                    ovf_s3;

	if (FRAC_BITS > IO_FRAC) begin : g_dn
		localparam int SH = FRAC_BITS - IO_FRAC;
		assign mag_sc = MG_W'((mag_s2 + (SUM_W'(1) << (SH - 1))) >> SH);
	end else if (FRAC_BITS < IO_FRAC) begin : g_up
		assign mag_sc = MG_W'(mag_s2) << (IO_FRAC - FRAC_BITS);
	end else begin : g_eq
		assign mag_sc = MG_W'(mag_s2);
	end

	assign lim = neg_s2 ? LIM_NEG : LIM_POS;
	assign ovf = mag_sc > lim;
	assign m32 = ovf ? lim[ANGLE_W-1:0] : mag_sc[ANGLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= tss_accum(in_ctx.sum, in_t, in_ctx.xneg ^ K_ODD, NT_W'(K) < in_nt);

			neg_s2 <= sum_s1[SUM_W-1];
			mag_s2 <= sum_s1[SUM_W-1] ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);

			sine_s3 <= neg_s2 ? (~m32 + 1'b1) : m32;
			ovf_s3  <= ovf;
		end
	end

	assign out_valid = v_s3;
	assign sine      = sine_s3;
	assign overflow  = ovf_s3;

endmodule

// ----- sv/taylor_series_sine.sv -----
// ----------------------------------------------------------------------------
// taylor_series_sine
// Throughput: one beat per cycle; every term owns its multipliers, so nothing
// is shared and the pipeline takes a new angle each cycle it is not stalled.
// Reset: async, active low; clears pipeline valid bits and the output queue,
// num_terms returns to 8. No clearing pass, usable right after reset.
// ----------------------------------------------------------------------------
//
// sin(x) = x - x^3/3! + x^5/5! - ..., summed over min(num_terms, MAX_TERMS)
// terms. Magnitudes are carried sign-less; each term is derived from the one
// before it as round(round(t * x^2) / ((2k)(2k+1))), with the divide done by a
// reciprocal multiply and a single remainder correction.
//
// Pipeline:
//   front : |x|, x^2                           3 stages
//   term k: add term k-1, build term k         6 stages, k = 1..MAX_TERMS-1
//   final : add last term, rescale, saturate   3 stages
//   queue : two-entry output buffer            1 stage
// The whole pipeline advances together whenever the output queue has room,
// so s_axis_tready is a flop decode and does not depend on m_axis_tready.
// An item that emerges while the queue holds one beat still gets a slot.
//
module taylor_series_sine import tss_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// config: num_terms
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [NUM_TERMS_W-1:0] cfg_data,

	// input beats
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [ANGLE_W-1:0]     s_axis_tdata,   // [31:0] angle, Q3.28

	// output beats
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [ANGLE_W-1:0]     m_axis_tdata,   // [31:0] sine, Q3.28
	output logic                   m_axis_tuser    // [0] overflow (saturated)
);

	localparam int NT_W   = $clog2(MAX_TERMS + 1);
	localparam int QDEPTH = 2;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// config register
	logic [NUM_TERMS_W-1:0] num_terms_q;
	logic [NT_W-1:0]        nt_eff;

	// global advance
	logic adv;

	// term chain taps
	logic            v_c   [MAX_TERMS];
	tss_ctx_t        ctx_c [MAX_TERMS];
	logic [T_W-1:0]  t_c   [MAX_TERMS];
	logic [NT_W-1:0] nt_c  [MAX_TERMS];

	// end of pipe
	logic               fin_valid;
	logic [ANGLE_W-1:0] fin_sine;
	logic               fin_ovf;

	// output queue
	logic [ANGLE_W-1:0] q_sine_q [QDEPTH];
	logic               q_ovf_q  [QDEPTH];
	logic               wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_terms_q <= NUM_TERMS_RST;
		end else if (cfg_valid) begin
			num_terms_q <= cfg_data;
		end
	end

	// term count above MAX_TERMS acts as MAX_TERMS
	assign nt_eff = (int'(num_terms_q) > MAX_TERMS) ? NT_W'(MAX_TERMS) : NT_W'(num_terms_q);

	assign adv           = cnt_q != QCNT_W'(QDEPTH);
	assign s_axis_tready = adv;

	tss_front #(
		.NT_W (NT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_axis_tvalid),
		.angle     (s_axis_tdata),
		.in_nt     (nt_eff),
		.out_valid (v_c[0]),
		.out_ctx   (ctx_c[0]),
		.out_t     (t_c[0]),
		.out_nt    (nt_c[0])
	);

	for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
		tss_term #(
			.K    (k),
			.NT_W (NT_W)
		) u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (v_c[k-1]),
			.in_ctx    (ctx_c[k-1]),
			.in_t      (t_c[k-1]),
			.in_nt     (nt_c[k-1]),
			.out_valid (v_c[k]),
			.out_ctx   (ctx_c[k]),
			.out_t     (t_c[k]),
			.out_nt    (nt_c[k])
		);
	end

	tss_final #(
		.K    (MAX_TERMS - 1),
		.NT_W (NT_W)
	) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_c[MAX_TERMS-1]),
		.in_ctx    (ctx_c[MAX_TERMS-1]),
		.in_t      (t_c[MAX_TERMS-1]),
		.in_nt     (nt_c[MAX_TERMS-1]),
		.out_valid (fin_valid),
		.sine      (fin_sine),
		.overflow  (fin_ovf)
	);

	// output queue: adv only when a slot is free, so a push never overruns
	assign push = adv && fin_valid;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q ^ push;
			rd_ptr_q <= rd_ptr_q ^ pop;
			cnt_q    <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_sine_q[wr_ptr_q] <= fin_sine;
			q_ovf_q[wr_ptr_q]  <= fin_ovf;
		end
	end

	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = q_sine_q[rd_ptr_q];
	assign m_axis_tuser  = q_ovf_q[rd_ptr_q];

endmodule
